/* sv/block_buffer_cache_lru_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the block buffer cache core
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define BBC_ASSERT_SAME(lbl, ck, rst_n, ante, cons)
`define BBC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif

`endif

/* sv/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes of the block buffer cache core.
// ----------------------------------------------------------------------------
package bbc_pkg;

	typedef enum logic [1:0] {
		REQ_ACQUIRE = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_PIN     = 2'd2,
		REQ_UNPIN   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_UNDER  = 2'd2,
		STAT_OVER   = 2'd3
	} status_t;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// One buffer table entry.
	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
		logic [31:0] stamp;
		logic        loaded;
	} entry_t;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic clear;
		logic sample;
		logic force_match;
	} scan_ctl_t;

	// What the scan unit has found so far.
	typedef struct packed {
		logic        match_found;
		entry_t      match_entry;
		logic        best_found;
		logic [31:0] best_stamp;
	} scan_res_t;

endpackage

/* sv/bbc_table.sv */
// ----------------------------------------------------------------------------
// bbc_table
// Buffer entry memory with one registered read port, one write port and
// per-entry valid bits; an entry never written reads as all zero.
// ----------------------------------------------------------------------------
module bbc_table
	import bbc_pkg::*;
#(
	parameter int NUM_BUFFERS = 32,
	parameter int SW          = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [SW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [SW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t                 mem_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] vld_q;
	entry_t                 rd_data_s1;
	logic                   rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

/* sv/bbc_scan.sv */
// ----------------------------------------------------------------------------
// bbc_scan
// Shared compare unit: one entry per cycle, tracks the first tag match and
// the oldest unreferenced entry.
// ----------------------------------------------------------------------------
module bbc_scan
	import bbc_pkg::*;
#(
	parameter int SW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scan_ctl_t     ctl,
	input  logic [SW-1:0] idx,
	input  entry_t        ent,
	input  logic [7:0]    req_dev,
	input  logic [31:0]   req_blk,
	output scan_res_t     res,
	output logic [SW-1:0] match_idx,
	output logic [SW-1:0] best_idx
);

	logic        match_found_q;
	logic        best_found_q;
	entry_t      match_entry_q;
	logic [31:0] best_stamp_q;
	logic [SW-1:0] match_idx_q;
	logic [SW-1:0] best_idx_q;
	logic        tag_hit;
	logic        take_match;
	logic        take_best;

	assign tag_hit    = (ent.dev == req_dev) && (ent.blk == req_blk);
	assign take_match = ctl.sample && !match_found_q && (ctl.force_match || tag_hit);
	assign take_best  = ctl.sample && (ent.cnt == 8'd0)
		&& (!best_found_q || (ent.stamp < best_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
		end else if (ctl.clear) begin
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
		end else begin
			if (take_match) begin
				match_found_q <= 1'b1;
			end
			if (take_best) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			match_entry_q <= ent;
			match_idx_q   <= idx;
		end
		if (take_best) begin
			best_stamp_q <= ent.stamp;
			best_idx_q   <= idx;
		end
	end

	assign res.match_found = match_found_q;
	assign res.match_entry = match_entry_q;
	assign res.best_found  = best_found_q;
	assign res.best_stamp  = best_stamp_q;
	assign match_idx       = match_idx_q;
	assign best_idx        = best_idx_q;

endmodule

/* sv/block_buffer_cache_lru_core.sv */
// Acquire: the accepting idle state, a scan state that reads every entry in turn, a
// drain state that lets the last read reach the compare unit and a write state
// that updates the entry and loads the result. Release, pin and unpin pass the same
// states but read only their one entry; an out-of-range slot skips scan and drain.
// The single read port, one entry a cycle, sets the rate; output stalls add to it.
// Reset clears the sequencer, the output valid and every entry's valid bit.
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_core
// Buffer cache with reference counts and oldest-release replacement, built as
// a small sequencer driving one compare unit over an entry memory with one read port.
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lru_core_defines.svh"

module block_buffer_cache_lru_core
	import bbc_pkg::*;
#(
	parameter int NUM_BUFFERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  device_id,
	input  logic [31:0] block_number,
	input  logic [4:0]  buffer_slot,
	input  logic [31:0] now_tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  slot_out,
	output logic        was_hit,
	output logic        needs_read,
	output logic [1:0]  status
);

	localparam int SW = $clog2(NUM_BUFFERS);
	localparam logic [SW-1:0] LAST_IDX = SW'(NUM_BUFFERS - 1);

	// Sequencer states. A beat is taken only in idle; the scan state issues one
	// memory read per cycle, the drain state lets the last read reach the
	// compare unit, and the write state updates the entry and loads the result.
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	state_t        state_q;
	logic [SW-1:0] cnt_q;
	req_t          req_q;
	logic [7:0]    dev_q;
	logic [31:0]   blk_q;
	logic [4:0]    slot_q;
	logic [31:0]   tick_q;
	logic          in_rng_q;

	logic          smp_s1;
	logic [SW-1:0] idx_s1;

	logic          out_valid_q;
	logic [4:0]    slot_out_q;
	logic          was_hit_q;
	logic          needs_read_q;
	status_t       status_q;

	logic          accept;
	logic          acq;
	logic          out_free;
	logic          go;
	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] slot_idx;
	entry_t        rd_data;
	scan_ctl_t     scan_ctl;
	scan_res_t     scan_res;
	logic [SW-1:0] match_idx;
	logic [SW-1:0] best_idx;

	logic          wr_req;
	logic          tbl_wr_en;
	logic [SW-1:0] wr_addr;
	entry_t        wr_data;
	logic [4:0]    res_slot;
	logic          res_hit;
	logic          res_read;
	status_t       res_stat;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign acq      = (req_q == REQ_ACQUIRE);
	assign slot_idx = SW'(slot_q);
	assign out_free = !out_valid_q || !out_stall;
	assign go       = (state_q == S_WRITE) && out_free;

	// An acquire walks every entry; the other requests read their one slot.
	assign rd_en   = (state_q == S_SCAN);
	assign rd_addr = acq ? cnt_q : slot_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			smp_s1  <= 1'b0;
		end else begin
			smp_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if ((req_type == REQ_ACQUIRE)
							|| (32'(buffer_slot) < 32'(NUM_BUFFERS))) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_SCAN: begin
					if (!acq || (cnt_q == LAST_IDX)) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields are held for the whole walk.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (accept) begin
			req_q    <= req_t'(req_type);
			dev_q    <= device_id;
			blk_q    <= block_number;
			slot_q   <= buffer_slot;
			tick_q   <= now_tick;
			in_rng_q <= (32'(buffer_slot) < 32'(NUM_BUFFERS));
		end
	end

	assign scan_ctl.clear       = accept;
	assign scan_ctl.sample      = smp_s1;
	assign scan_ctl.force_match = !acq;

	bbc_table #(
		.NUM_BUFFERS(NUM_BUFFERS),
		.SW         (SW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (tbl_wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	bbc_scan #(
		.SW(SW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (idx_s1),
		.ent      (rd_data),
		.req_dev  (dev_q),
		.req_blk  (blk_q),
		.res      (scan_res),
		.match_idx(match_idx),
		.best_idx (best_idx)
	);

	// Update of the chosen entry and the result of the request. A hit keeps
	// its tag and stamp; a miss retags the oldest free entry and keeps its
	// stamp. The count saturates at both ends and then reports a status.
	always_comb begin
		wr_req   = 1'b0;
		wr_addr  = match_idx;
		wr_data  = scan_res.match_entry;
		res_slot = slot_q;
		res_hit  = 1'b0;
		res_read = 1'b0;
		res_stat = STAT_OK;
		case (req_q) inside
			REQ_ACQUIRE: begin
				res_slot = 5'd0;
				if (scan_res.match_found) begin
					wr_req         = 1'b1;
					wr_data.loaded = 1'b1;
					res_slot       = 5'(match_idx);
					res_hit        = 1'b1;
					res_read       = !scan_res.match_entry.loaded;
					if (scan_res.match_entry.cnt == COUNT_MAX) begin
						res_stat = STAT_OVER;
					end else begin
						wr_data.cnt = scan_res.match_entry.cnt + 8'd1;
					end
				end else if (scan_res.best_found) begin
					wr_req         = 1'b1;
					wr_addr        = best_idx;
					wr_data.dev    = dev_q;
					wr_data.blk    = blk_q;
					wr_data.cnt    = 8'd1;
					wr_data.stamp  = scan_res.best_stamp;
					wr_data.loaded = 1'b1;
					res_slot       = 5'(best_idx);
					res_read       = 1'b1;
				end else begin
					res_stat = STAT_NOFREE;
				end
			end
			REQ_PIN: begin
				if (in_rng_q) begin
					if (scan_res.match_entry.cnt == COUNT_MAX) begin
						res_stat = STAT_OVER;
					end else begin
						wr_req      = 1'b1;
						wr_data.cnt = scan_res.match_entry.cnt + 8'd1;
					end
				end
			end
			REQ_RELEASE, REQ_UNPIN: begin
				if (in_rng_q) begin
					if (scan_res.match_entry.cnt == 8'd0) begin
						res_stat = STAT_UNDER;
					end else begin
						wr_req      = 1'b1;
						wr_data.cnt = scan_res.match_entry.cnt - 8'd1;
						// The final release records when the buffer went free.
						if ((req_q == REQ_RELEASE) && (scan_res.match_entry.cnt == 8'd1)) begin
							wr_data.stamp = tick_q;
						end
					end
				end
			end
		endcase
	end

	assign tbl_wr_en = wr_req && go;

	// Output register: holds a finished beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			slot_out_q   <= res_slot;
			was_hit_q    <= res_hit;
			needs_read_q <= res_read;
			status_q     <= res_stat;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_out   = slot_out_q;
	assign was_hit    = was_hit_q;
	assign needs_read = needs_read_q;
	assign status     = status_q;

	// A taken beat closes the input until its result has been produced.
	`BBC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, in_stall)
	// The entry memory is written only while the result is being loaded.
	`BBC_ASSERT_SAME(a_write_in_update, clk, arst_n, tbl_wr_en, go)
	// A miss with no free entry reports slot zero, no hit and no read.
	`BBC_ASSERT_SAME(a_nofree_fields, clk, arst_n, out_valid && (status == STAT_NOFREE), (slot_out == 5'd0) && !was_hit && !needs_read)
	// Only an acquire may report a hit, and an acquire never underflows.
	`BBC_ASSERT_SAME(a_hit_not_under, clk, arst_n, out_valid && was_hit, status != STAT_UNDER)

endmodule

/* dv/block_buffer_cache_lru_core_test.sv */
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_core_test
// Self-checking bench for the buffer cache core. A behavioral copy of the
// entry table predicts every reply as its request beat is accepted. The reply
// stream is compared against those predictions field by field. Both sides of
// the block idle and stall at random between beats.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bbc_pkg::*;

	localparam int ENTRIES = 32;

	// One request as queued for the driver, with the idle cycles that precede it.
	typedef struct {
		req_t        kind;
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [4:0]  slot;
		logic [31:0] tick;
		int          gap;
	} cache_req_t;

	// One reply as the block should return it.
	typedef struct packed {
		logic [4:0] slot;
		logic       hit;
		logic       rd;
		status_t    st;
	} cache_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_ACQUIRE;
	logic [7:0]  device_id = '0;
	logic [31:0] block_number = '0;
	logic [4:0]  buffer_slot = '0;
	logic [31:0] now_tick = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  slot_out;
	logic        was_hit;
	logic        needs_read;
	logic [1:0]  status;

	// Behavioral copy of the entry table. Everything starts at zero, as the
	// block's reset leaves it.
	logic [7:0]  tbl_dev    [ENTRIES] = '{default: '0};
	logic [31:0] tbl_blk    [ENTRIES] = '{default: '0};
	logic [7:0]  tbl_cnt    [ENTRIES] = '{default: '0};
	logic [31:0] tbl_stamp  [ENTRIES] = '{default: '0};
	logic        tbl_loaded [ENTRIES] = '{default: 1'b0};

	cache_req_t   queued_requests [$];
	cache_reply_t pending_replies [$];
	cache_req_t   live_req;

	int issued_count = 0;
	int driven_count = 0;
	int gap_count = 0;
	int stall_left = 0;
	int fault_count = 0;

	// Upper bounds for the random idle cycles on each side. The tests change
	// them to get both busy stretches and gaps that fall on every phase.
	int max_gap = 10;
	int max_stall = 10;

	block_buffer_cache_lru_core #(
		.NUM_BUFFERS(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.device_id(device_id),
		.block_number(block_number),
		.buffer_slot(buffer_slot),
		.now_tick(now_tick),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slot_out(slot_out),
		.was_hit(was_hit),
		.needs_read(needs_read),
		.status(status)
	);

	always #6 clk = ~clk;

	// Reset is asserted from time zero and released on a falling edge.
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Applies one request to the table copy and returns the reply it causes.
	// An acquire first looks for the lowest entry that carries the tag. On a
	// miss it takes the free entry with the oldest release stamp, where the
	// strict compare keeps the lowest index on a tie.
	function automatic cache_reply_t serve_request(cache_req_t r);
		cache_reply_t reply;
		int pick;
		bit found;
		reply = '{slot: r.slot, hit: 1'b0, rd: 1'b0, st: STAT_OK};
		pick = 0;
		found = 1'b0;
		if (r.kind == REQ_ACQUIRE) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (!found && tbl_dev[i] == r.dev && tbl_blk[i] == r.blk) begin
					pick = i;
					found = 1'b1;
				end
			end
			if (found) begin
				// A hit on a saturated count is still granted, only flagged.
				if (tbl_cnt[pick] == COUNT_MAX)
					reply.st = STAT_OVER;
				else
					tbl_cnt[pick]++;
				reply.slot = 5'(pick);
				reply.hit = 1'b1;
				reply.rd = !tbl_loaded[pick];
				tbl_loaded[pick] = 1'b1;
				return reply;
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (tbl_cnt[i] == 0 && (!found || tbl_stamp[i] < tbl_stamp[pick])) begin
					pick = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				// Every entry is referenced: the table is left alone.
				reply.slot = '0;
				reply.st = STAT_NOFREE;
				return reply;
			end
			tbl_dev[pick] = r.dev;
			tbl_blk[pick] = r.blk;
			tbl_cnt[pick] = 8'd1;
			tbl_loaded[pick] = 1'b1;
			reply.slot = 5'(pick);
			reply.rd = 1'b1;
		end else if (r.slot < ENTRIES) begin
			if (r.kind == REQ_PIN) begin
				if (tbl_cnt[r.slot] == COUNT_MAX)
					reply.st = STAT_OVER;
				else
					tbl_cnt[r.slot]++;
			end else if (tbl_cnt[r.slot] == 0) begin
				reply.st = STAT_UNDER;
			end else begin
				tbl_cnt[r.slot]--;
				// Only the release that drops the last reference stamps the entry.
				if (r.kind == REQ_RELEASE && tbl_cnt[r.slot] == 0)
					tbl_stamp[r.slot] = r.tick;
			end
		end
		return reply;
	endfunction

	function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fault_count++;
		end
	endfunction

	// Request driver. It owns in_valid and the payload, so each of them gets
	// at most one assignment per edge. A beat that is accepted at this edge is
	// predicted at once; then, if the input is free, the next queued request
	// is presented after its idle cycles have run out. With no idle cycles the
	// next beat follows the accepted one directly.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			pending_replies.push_back(serve_request(live_req));
		if (!in_valid || !in_stall) begin
			if (queued_requests.size() != 0 && gap_count >= queued_requests[0].gap) begin
				live_req = queued_requests.pop_front();
				req_type <= live_req.kind;
				device_id <= live_req.dev;
				block_number <= live_req.blk;
				buffer_slot <= live_req.slot;
				now_tick <= live_req.tick;
				in_valid <= 1'b1;
				gap_count = 0;
				driven_count++;
			end else begin
				in_valid <= 1'b0;
				if (queued_requests.size() != 0)
					gap_count++;
			end
		end
	end

	// Reply checker. Each accepted reply beat is matched against the oldest
	// prediction. After every reply the receiver draws how long it stalls
	// before it takes the next one.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$error("reply beat with nothing outstanding: slot_out %0d status %0d",
					slot_out, status);
				fault_count++;
			end else begin
				cache_reply_t want;
				want = pending_replies.pop_front();
				compare_field("slot_out", 32'(want.slot), 32'(slot_out));
				compare_field("was_hit", 32'(want.hit), 32'(was_hit));
				compare_field("needs_read", 32'(want.rd), 32'(needs_read));
				compare_field("status", 32'(want.st), 32'(status));
			end
			stall_left = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
		end else if (stall_left != 0) begin
			stall_left--;
		end
		out_stall <= (stall_left != 0);
	end

	// Queues one request and returns once the driver has put it on the port.
	// The test process only moves on falling edges, so the driver never races
	// with a push. Returning before acceptance lets the next request follow
	// back to back; the table copy may then be one beat behind when a test
	// looks at it to choose a slot, which only affects the choice.
	task automatic send_request(req_t kind, logic [7:0] dev, logic [31:0] blk,
			logic [4:0] slot, logic [31:0] tick);
		cache_req_t r;
		int ticket;
		r.kind = kind;
		r.dev = dev;
		r.blk = blk;
		r.slot = slot;
		r.tick = tick;
		r.gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
		ticket = issued_count;
		issued_count++;
		queued_requests.push_back(r);
		do @(negedge clk); while (driven_count <= ticket);
	endtask

	// After reset every entry carries tag (0,0) and is not loaded, so the
	// first acquire of that tag hits the lowest entry and still needs a read.
	// The second one hits the same entry, now loaded.
	task automatic test_reset_tags();
		max_gap = 10;
		max_stall = 10;
		send_request(REQ_ACQUIRE, 8'h00, 32'h0000_0000, 5'd17, $urandom());
		send_request(REQ_ACQUIRE, 8'h00, 32'h0000_0000, 5'd31, $urandom());
	endtask

	// Field extremes, every request kind, underflow on an idle entry, a hit on
	// an entry whose count has dropped to zero, and ties between free entries
	// that all carry stamp zero.
	task automatic test_field_extremes();
		max_gap = 0;
		max_stall = 0;
		send_request(REQ_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);
		send_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'hFFFF_FFFF);
		send_request(REQ_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd1, 32'h1234_5678);
		send_request(REQ_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000);
		send_request(REQ_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
		send_request(REQ_UNPIN, 8'hAA, 32'h5555_5555, 5'd31, 32'hAAAA_AAAA);
		max_gap = 10;
		max_stall = 10;
		send_request(REQ_ACQUIRE, 8'h00, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
		send_request(REQ_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);
		send_request(REQ_ACQUIRE, 8'hFF, 32'h0000_0000, 5'd21, 32'h5555_5555);
		send_request(REQ_RELEASE, 8'h55, 32'hAAAA_AAAA, 5'd0, 32'h0000_0000);
		send_request(REQ_RELEASE, 8'h55, 32'hAAAA_AAAA, 5'd0, 32'h0000_0007);
		send_request(REQ_PIN, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
		send_request(REQ_UNPIN, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
		send_request(REQ_ACQUIRE, 8'h5A, 32'hA5A5_A5A5, 5'd10, 32'h0000_0000);
	endtask

	// Takes a reference on every entry until none is free, shows that a miss
	// is then refused, and frees the table again with scattered stamps so that
	// the following misses must pick entries in order of their stamps.
	task automatic test_full_table();
		bit free_seen;
		max_gap = 3;
		max_stall = 3;
		for (int n = 0; n < 40; n++) begin
			free_seen = 1'b0;
			for (int i = 0; i < ENTRIES; i++)
				if (tbl_cnt[i] == 0)
					free_seen = 1'b1;
			if (!free_seen)
				break;
			send_request(REQ_ACQUIRE, 8'(n), $urandom(), 5'(n), $urandom());
		end
		send_request(REQ_ACQUIRE, 8'hC3, $urandom(), 5'd31, $urandom());
		send_request(REQ_ACQUIRE, 8'h3C, $urandom(), 5'd0, $urandom());
		max_gap = 10;
		max_stall = 10;
		for (int i = 0; i < ENTRIES; i++)
			while (tbl_cnt[i] != 0)
				send_request(REQ_RELEASE, 8'($urandom_range(0, 255)), $urandom(), 5'(i),
					$urandom());
		repeat (6)
			send_request(REQ_ACQUIRE, 8'($urandom_range(0, 255)), $urandom(),
				5'($urandom_range(0, ENTRIES - 1)), $urandom());
	endtask

	// Drives one count to saturation with pins, then checks that a further pin
	// and an acquire hit both report overflow while the hit is still granted.
	task automatic test_count_saturation();
		max_gap = 0;
		max_stall = 2;
		for (int n = 0; n < 300 && tbl_cnt[ENTRIES - 1] != COUNT_MAX; n++)
			send_request(REQ_PIN, 8'($urandom_range(0, 255)), $urandom(), 5'(ENTRIES - 1),
				$urandom());
		send_request(REQ_PIN, 8'h00, 32'h0000_0000, 5'(ENTRIES - 1), 32'h0000_0000);
		max_gap = 10;
		max_stall = 10;
		send_request(REQ_ACQUIRE, tbl_dev[ENTRIES - 1], tbl_blk[ENTRIES - 1], 5'd3, $urandom());
		send_request(REQ_UNPIN, 8'h00, 32'h0000_0000, 5'(ENTRIES - 1), 32'h0000_0000);
		send_request(REQ_UNPIN, 8'h00, 32'h0000_0000, 5'(ENTRIES - 1), 32'h0000_0000);
		send_request(REQ_ACQUIRE, tbl_dev[ENTRIES - 1], tbl_blk[ENTRIES - 1], 5'd9, $urandom());
	endtask

	// Random traffic shaped like real use. Most acquires draw from a small
	// set of tags so that hits and retags both happen; most releases and many
	// unpins address entries that hold references, so the table fills and
	// drains. Ticks mostly advance, with an occasional arbitrary value. The
	// unused fields of each beat carry random values. Idle settings change
	// every thirty beats.
	task automatic test_random_traffic(int count);
		logic [7:0]  pool_dev [48];
		logic [31:0] pool_blk [48];
		logic [31:0] tick;
		logic [31:0] stamp;
		logic [4:0]  slot;
		int          held [$];
		int          roll;
		int          pick;
		tick = $urandom_range(1000, 5000);
		for (int i = 0; i < 48; i++) begin
			pool_dev[i] = 8'($urandom_range(0, 255));
			pool_blk[i] = $urandom();
		end
		for (int n = 0; n < count; n++) begin
			if (n % 30 == 0) begin
				case ((n / 30) % 4)
					0: begin
						max_gap = 10;
						max_stall = 10;
					end
					1: begin
						max_gap = 0;
						max_stall = 0;
					end
					2: begin
						max_gap = 0;
						max_stall = 10;
					end
					default: begin
						max_gap = 10;
						max_stall = 0;
					end
				endcase
			end
			tick += $urandom_range(1, 1000);
			stamp = ($urandom_range(0, 9) == 0) ? $urandom() : tick;
			held.delete();
			for (int i = 0; i < ENTRIES; i++)
				if (tbl_cnt[i] != 0)
					held.push_back(i);
			slot = 5'($urandom_range(0, ENTRIES - 1));
			if (held.size() != 0 && $urandom_range(0, 99) < 80)
				slot = 5'(held[$urandom_range(0, held.size() - 1)]);
			roll = $urandom_range(0, 99);
			pick = $urandom_range(0, 47);
			if (roll < 35) begin
				if ($urandom_range(0, 3) == 0)
					send_request(REQ_ACQUIRE, 8'($urandom_range(0, 255)), $urandom(),
						5'($urandom_range(0, ENTRIES - 1)), stamp);
				else
					send_request(REQ_ACQUIRE, pool_dev[pick], pool_blk[pick],
						5'($urandom_range(0, ENTRIES - 1)), stamp);
			end else if (roll < 80) begin
				send_request(REQ_RELEASE, 8'($urandom_range(0, 255)), $urandom(), slot,
					stamp);
			end else if (roll < 88) begin
				send_request(REQ_PIN, 8'($urandom_range(0, 255)), $urandom(),
					5'($urandom_range(0, ENTRIES - 1)), stamp);
			end else begin
				if ($urandom_range(0, 9) < 6)
					send_request(REQ_UNPIN, 8'($urandom_range(0, 255)), $urandom(), slot,
						stamp);
				else
					send_request(REQ_UNPIN, 8'($urandom_range(0, 255)), $urandom(),
						5'($urandom_range(0, ENTRIES - 1)), stamp);
			end
		end
	endtask

	// Test sequence. The run ends once every request has been sent and every
	// reply has come back, plus a margin longer than one full acquire scan so
	// that a stray extra reply would still be seen.
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		test_reset_tags();
		test_field_extremes();
		test_full_table();
		test_count_saturation();
		test_random_traffic(150);
		while (queued_requests.size() != 0 || in_valid || pending_replies.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog for a block that stops answering. The slowest correct run is
	// well under a millisecond.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
